// ===== src/dfs_pkg.sv =====
// Shared constants for the delimited field selector: register map and range layout.
`default_nettype none

package dfs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_ZERO  = 3'd2;

    localparam logic [7:0]  DELIMITER_RESET = 8'h2D;
    localparam int          RANGE_FIELD_W   = 16;
    localparam logic [15:0] NO_END          = 16'hFFFF;

endpackage : dfs_pkg

`default_nettype wire

// ===== src/delimited_field_selector_top.sv =====
// Delimited field selector: streams a string through and keeps the selected fields.
// Each input byte goes through the input register, the range pick and the result register.
// Throughput: one byte per cycle while the output does not stall.
// A byte that yields no output byte and is not a string's last byte gives no output.
// Reset (synchronous, active low) empties both registers, restores the register
// defaults (hyphen delimiter, no ranges) and puts the block at a string start.
`default_nettype none

module delimited_field_selector_top
    import dfs_pkg::*;
#(
    parameter int MAX_RANGES = 4,
    parameter int FIELD_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // configuration write port
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire [7:0]             i_s_axis_tdata,   // [7:0] in_byte
    input  wire                   i_s_axis_tlast,   // last_byte
    // output stream
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [7:0] out_byte
    output logic                  o_m_axis_tuser,   // [0] byte_valid
    output logic                  o_m_axis_tlast    // string_end
);

    localparam int PW = $clog2(MAX_RANGES + 1);
    localparam int FB = FIELD_BITS;
    localparam int CW = (FB > RANGE_FIELD_W) ? FB : RANGE_FIELD_W;

    typedef struct packed {
        logic          sel;
        logic [PW-1:0] ptr;
    } t_pick;

    // configuration
    logic [7:0]  r_delim;
    logic [2:0]  r_count;
    logic [31:0] r_range [MAX_RANGES];

    // string state
    logic [FB-1:0] r_fn;
    logic [PW-1:0] r_rp;
    logic          r_any;
    logic          r_sel;
    logic          r_start;

    // input register
    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          r_in_last;

    // result register
    logic          r_o_vld;
    logic [7:0]    r_o_byte;
    logic          r_o_bv;
    logic          r_o_last;

    logic          w_go;
    logic [PW-1:0] w_n;
    t_pick         w_pick0;
    t_pick         w_pick1;
    logic [FB-1:0] w_fn_a;
    logic [PW-1:0] w_rp_a;
    logic          w_sel_a;
    logic          w_any_a;
    logic [FB-1:0] w_fn_b;
    logic          w_is_delim;
    logic [FB-1:0] n_fn;
    logic [PW-1:0] n_rp;
    logic          n_any;
    logic          n_sel;
    logic          n_bv;
    logic [7:0]    n_byte;

    // Walk the ranges from ptr on: drop passed ones, stop at the first not yet passed.
    function automatic t_pick f_choose(input logic [FB-1:0] fn, input logic [PW-1:0] ptr);
        t_pick         res;
        logic          done;
        logic [CW-1:0] f;
        logic [CW-1:0] st;
        logic [CW-1:0] sp;
        res.sel = 1'b0;
        res.ptr = ptr;
        done    = 1'b0;
        f       = CW'(fn);
        for (int i = 0; i < MAX_RANGES; i++) begin
            st = CW'(r_range[i][15:0]);
            sp = CW'(r_range[i][31:16]);
            if (!done && (PW'(i) >= ptr) && (PW'(i) < w_n)) begin
                if (f < st) begin
                    done    = 1'b1;
                    res.ptr = PW'(i);
                end else if ((r_range[i][31:16] == NO_END) || (f <= sp)) begin
                    done    = 1'b1;
                    res.sel = 1'b1;
                    res.ptr = PW'(i);
                end
            end
        end
        if (!done && (ptr < w_n)) begin
            res.ptr = w_n;
        end
        return res;
    endfunction

    assign w_go            = r_in_vld && (!r_o_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_go;

    assign w_n = (r_count > 3'(MAX_RANGES)) ? PW'(MAX_RANGES) : PW'(r_count);

    always_comb begin
        w_pick0 = f_choose(FB'(1), '0);
        if (r_start) begin
            w_fn_a  = FB'(1);
            w_rp_a  = w_pick0.ptr;
            w_sel_a = w_pick0.sel;
            w_any_a = w_pick0.sel;
        end else begin
            w_fn_a  = r_fn;
            w_rp_a  = r_rp;
            w_sel_a = r_sel;
            w_any_a = r_any;
        end
        // saturate the field counter
        w_fn_b     = (w_fn_a != '1) ? (w_fn_a + FB'(1)) : w_fn_a;
        w_pick1    = f_choose(w_fn_b, w_rp_a);
        w_is_delim = (r_in_byte == r_delim);
        if (w_is_delim) begin
            n_fn   = w_fn_b;
            n_rp   = w_pick1.ptr;
            n_sel  = w_pick1.sel;
            n_any  = w_any_a || w_pick1.sel;
            n_bv   = w_pick1.sel && w_any_a;
            n_byte = (w_pick1.sel && w_any_a) ? r_delim : 8'h00;
        end else begin
            n_fn   = w_fn_a;
            n_rp   = w_rp_a;
            n_sel  = w_sel_a;
            n_any  = w_any_a;
            n_bv   = w_sel_a;
            n_byte = w_sel_a ? r_in_byte : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIMITER_RESET;
            r_count <= '0;
            for (int k = 0; k < MAX_RANGES; k++) begin
                r_range[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DELIMITER:   r_delim <= i_cfg_data[7:0];
                REG_RANGE_COUNT: r_count <= i_cfg_data[2:0];
                default: begin
                    for (int k = 0; k < MAX_RANGES; k++) begin
                        if (i_cfg_idx == CFG_IDX_W'(int'(REG_RANGE_ZERO) + k)) begin
                            r_range[k] <= i_cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn    <= FB'(1);
            r_rp    <= '0;
            r_any   <= 1'b0;
            r_sel   <= 1'b0;
            r_start <= 1'b1;
            r_o_vld <= 1'b0;
        end else if (w_go) begin
            r_fn    <= n_fn;
            r_rp    <= n_rp;
            r_any   <= n_any;
            r_sel   <= n_sel;
            r_start <= r_in_last;
            // drop bytes that give neither data nor a string end
            r_o_vld <= n_bv || r_in_last;
        end else if (i_m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
        if (w_go) begin
            r_o_byte <= n_byte;
            r_o_bv   <= n_bv;
            r_o_last <= r_in_last;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_byte;
    assign o_m_axis_tuser  = r_o_bv;
    assign o_m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser || o_m_axis_tlast))
        else $error("result transaction carries neither a byte nor a string end");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == 8'h00))
        else $error("out_byte not zero without byte_valid");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("pending result lost during stall");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= PW'(MAX_RANGES))
        else $error("range pointer beyond range table");

    a_field_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fn != '0)
        else $error("field counter reached zero");
`endif

endmodule : delimited_field_selector_top

`default_nettype wire
